// File: src/dmm_pkg.sv
package dmm_pkg;

	// Field widths
	localparam int STATE_W   = 6;
	localparam int SYM_W     = 8;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OUT_POS_W = 16;

	// Transition entry: valid bit over target state
	localparam int ENTRY_W = STATE_W + 1;

	// Parameter defaults
	localparam int NUM_STATES_DEF    = 64;
	localparam int POSITION_BITS_DEF = 16;

	// Item modes
	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_LOAD = 2'd0;
	localparam mode_t MODE_FLAG = 2'd1;
	localparam mode_t MODE_SCAN = 2'd2;
	localparam mode_t MODE_END  = 2'd3;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_EXTEND   = 2'd0;
	localparam status_t ST_BOUNDARY = 2'd1;
	localparam status_t ST_ERROR    = 2'd2;
	localparam status_t ST_FINAL    = 2'd3;

	// Sequencer phases
	typedef enum logic [1:0] {
		PH_CLEAR,
		PH_IDLE,
		PH_LOOKUP,
		PH_RETRY
	} phase_t;

endpackage

// File: src/dfa_maximal_munch_scanner.sv
// A scan or end item is looked up in the transition memory and its result, if any, is
// registered; when a token ends, the byte is looked up again from the initial state.
// Throughput: one item per cycle while the output is not stalled and no token ends;
// the transition memory read (with the next state forwarded to its address) sets it.
// Reset: asynchronous, active low; then a clearing pass over NUM_STATES*256 entries
// (16384 by default) empties both tables; no item is accepted meanwhile, config is taken.
module dfa_maximal_munch_scanner
	import dmm_pkg::*;
#(
	parameter int NUM_STATES    = NUM_STATES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [STATE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [STATE_W-1:0]   state_index,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [STATE_W-1:0]   next_state,
	input  logic                 accepting,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [OUT_POS_W-1:0] position,
	output logic [SYM_W-1:0]     byte_out
);

	localparam int SW        = $clog2(NUM_STATES);
	localparam int AW        = SW + SYM_W;
	localparam int TBL_DEPTH = NUM_STATES * (1 << SYM_W);
	localparam logic [AW-1:0] CLR_LAST = AW'(TBL_DEPTH - 1);
	localparam logic [63:0] OUT_POS_MAX = (64'd1 << OUT_POS_W) - 64'd1;

	function automatic logic st_in_range(input logic [STATE_W-1:0] s);
		return int'(s) < NUM_STATES;
	endfunction

	function automatic logic [OUT_POS_W-1:0] pos_sat(input logic [POSITION_BITS-1:0] p);
		logic [OUT_POS_W-1:0] r;
		if (64'(p) > OUT_POS_MAX) begin
			r = '1;
		end else begin
			r = OUT_POS_W'(p);
		end
		return r;
	endfunction

	// Tables
	logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
	logic               acc_mem [NUM_STATES];

	phase_t                   phase_q, phase_d;
	logic [AW-1:0]            clr_cnt_q;
	logic [STATE_W-1:0]       init_q;
	logic [STATE_W-1:0]       cur_q, cur_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic                     empty_q, empty_d;
	logic                     err_q, err_d;
	logic [MODE_W-1:0]        mode_s1;
	logic [SYM_W-1:0]         sym_s1;
	logic [ENTRY_W-1:0]       rd_q;
	logic                     acc_rd_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic [OUT_POS_W-1:0]     pos_out_q;
	logic [SYM_W-1:0]         byte_q;

	logic          clearing, slot_free, st_ok, hit, acc_ok;
	logic          done, retry, emit;
	status_t       emit_status;
	logic [SYM_W-1:0] emit_byte;
	logic          in_take, take_lookup, rd_en;
	logic [SYM_W-1:0] rd_sym;
	logic [AW-1:0] rd_addr;
	logic          tbl_we, acc_we;
	logic [AW-1:0] tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic [SW-1:0] acc_waddr;
	logic          acc_wdata;

	assign clearing  = (phase_q == PH_CLEAR);
	assign slot_free = !out_valid_q || out_ready;
	assign st_ok     = st_in_range(cur_q);
	assign hit       = st_ok && rd_q[ENTRY_W-1];
	assign acc_ok    = st_ok && acc_rd_q;

	// Decide the outcome of the item under lookup
	always_comb begin
		cur_d       = cur_q;
		pos_d       = pos_q;
		empty_d     = empty_q;
		err_d       = err_q;
		done        = 1'b0;
		retry       = 1'b0;
		emit        = 1'b0;
		emit_status = ST_EXTEND;
		emit_byte   = sym_s1;
		case (phase_q)
			PH_LOOKUP: begin
				if (mode_s1 == MODE_END) begin
					done = slot_free;
					if (slot_free) begin
						if (!err_q) begin
							emit        = 1'b1;
							emit_status = acc_ok ? ST_FINAL : ST_ERROR;
							emit_byte   = '0;
						end
						cur_d   = init_q;
						pos_d   = '0;
						empty_d = 1'b1;
						err_d   = 1'b0;
					end
				end else if (err_q) begin
					done = 1'b1;
				end else if (hit) begin
					done = slot_free;
					if (slot_free) begin
						emit    = 1'b1;
						cur_d   = rd_q[STATE_W-1:0];
						empty_d = 1'b0;
						if (pos_q != '1) begin
							pos_d = pos_q + 1'b1;
						end
					end
				end else if (acc_ok && !empty_q) begin
					// token ends: retry the byte from the initial state
					retry   = 1'b1;
					cur_d   = init_q;
					empty_d = 1'b1;
				end else begin
					done = slot_free;
					if (slot_free) begin
						emit        = 1'b1;
						emit_status = ST_ERROR;
						err_d       = 1'b1;
					end
				end
			end
			PH_RETRY: begin
				done = slot_free;
				if (slot_free) begin
					emit = 1'b1;
					if (hit) begin
						emit_status = ST_BOUNDARY;
						cur_d       = rd_q[STATE_W-1:0];
						empty_d     = 1'b0;
						if (pos_q != '1) begin
							pos_d = pos_q + 1'b1;
						end
					end else begin
						emit_status = ST_ERROR;
						err_d       = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Input handshake and memory addressing (next state forwarded)
	assign in_ready    = (phase_q == PH_IDLE) || done;
	assign in_take     = in_valid && in_ready;
	assign take_lookup = in_take && (mode == MODE_SCAN || mode == MODE_END);
	assign rd_en       = take_lookup || retry;
	assign rd_sym      = retry ? sym_s1 : symbol;
	assign rd_addr     = {SW'(cur_d), rd_sym};
	assign cfg_ready   = 1'b1;

	// Table writes: clearing pass or load items
	assign tbl_we    = clearing || (in_take && mode == MODE_LOAD &&
		st_in_range(state_index) && st_in_range(next_state));
	assign tbl_waddr = clearing ? clr_cnt_q : {SW'(state_index), symbol};
	assign tbl_wdata = clearing ? '0 : {1'b1, next_state};
	assign acc_we    = clearing || (in_take && mode == MODE_FLAG && st_in_range(state_index));
	assign acc_waddr = clearing ? clr_cnt_q[AW-1:SYM_W] : SW'(state_index);
	assign acc_wdata = clearing ? 1'b0 : accepting;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_CLEAR: begin
				if (clr_cnt_q == CLR_LAST) begin
					phase_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (take_lookup) begin
					phase_d = PH_LOOKUP;
				end
			end
			PH_LOOKUP, PH_RETRY: begin
				if (retry) begin
					phase_d = PH_RETRY;
				end else if (done) begin
					phase_d = take_lookup ? PH_LOOKUP : PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Transition memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= tbl_mem[rd_addr];
		end
	end

	// Accepting flag memory
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			acc_rd_q <= acc_mem[SW'(cur_d)];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CLEAR;
			clr_cnt_q   <= '0;
			init_q      <= '0;
			cur_q       <= '0;
			pos_q       <= '0;
			empty_q     <= 1'b1;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			pos_q   <= pos_d;
			empty_q <= empty_d;
			err_q   <= err_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				init_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item under lookup
	always_ff @(posedge clk) begin
		if (take_lookup) begin
			mode_s1 <= mode;
			sym_s1  <= symbol;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= emit_status;
			pos_out_q <= pos_sat(pos_q);
			byte_q    <= emit_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = pos_out_q;
	assign byte_out  = byte_q;

endmodule

// File: src/dmm_checker.sv
module dmm_checker
	import dmm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STATUS_W-1:0]  status,
	input logic [OUT_POS_W-1:0] position,
	input logic [SYM_W-1:0]     byte_out
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position) &&
		$stable(byte_out))
		else $error("result changed while stalled");

	// End of input echoes no byte
	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FINAL |-> byte_out == '0)
		else $error("final token result carries a byte");

	// A fresh result must follow an accepted item, also when a retry lies between them
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready) || $past(in_valid && in_ready, 2) ||
		$past(in_valid && in_ready, 3))
		else $error("result without a recent item");

endmodule

bind dfa_maximal_munch_scanner dmm_checker u_dmm_checker (.*);

// File: dv/testbench.sv
module testbench
	import dmm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		mode_t              mode;
		logic [STATE_W-1:0] state_index;
		logic [SYM_W-1:0]   symbol;
		logic [STATE_W-1:0] next_state;
		logic               accepting;
	} scan_item_t;

	typedef struct packed {
		status_t              status;
		logic [OUT_POS_W-1:0] pos;
		logic [SYM_W-1:0]     echo;
	} token_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [STATE_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	scan_item_t         in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [OUT_POS_W-1:0] position;
	logic [SYM_W-1:0]     byte_out;

	// Scanner image: arc table, accepting flags, lexer state
	bit [ENTRY_W-1:0]   arc_tbl [NUM_STATES_DEF][256];
	bit                 accept_tbl [NUM_STATES_DEF];
	bit [STATE_W-1:0]   start_state;
	bit [STATE_W-1:0]   lex_state;
	bit [OUT_POS_W-1:0] lex_pos;
	bit                 lex_empty = 1'b1;
	bit                 lex_error;

	scan_item_t    pending_items[$];
	token_result_t token_q[$];
	int            items_queued;
	int            items_taken;
	int            fail_cnt;
	int            in_pause;
	int            in_calm;
	int            out_pause;
	int            out_calm;
	bit            quiet_tail;

	dfa_maximal_munch_scanner u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (in_item.mode),
		.state_index(in_item.state_index),
		.symbol     (in_item.symbol),
		.next_state (in_item.next_state),
		.accepting  (in_item.accepting),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.byte_out   (byte_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pick a stall: random bursts, calm stretches, none at the tail
	function automatic int next_pause(inout int calm_left);
		int r;
		if (quiet_tail)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 15);
		if (r == 0)
			calm_left = $urandom_range(20, 80);
		else if (r < 4)
			return $urandom_range(1, 13);
		return 0;
	endfunction

	function automatic void note_failure(string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Follow an arc: take its target state, mark the lexeme non-empty, bump the byte position, saturating
	function automatic void take_arc(bit [ENTRY_W-1:0] arc);
		lex_state = arc[STATE_W-1:0];
		lex_empty = 1'b0;
		if (lex_pos != '1)
			lex_pos++;
	endfunction

	// Apply one accepted item to the scanner image, queue its token result if it gives one
	function automatic void predict_token_result(scan_item_t it);
		bit [ENTRY_W-1:0] arc;
		status_t          st;
		case (it.mode)
			MODE_LOAD: arc_tbl[it.state_index][it.symbol] = {1'b1, it.next_state};
			MODE_FLAG: accept_tbl[it.state_index] = it.accepting;
			MODE_END: begin
				if (!lex_error)
					token_q.push_back({accept_tbl[lex_state] ? ST_FINAL : ST_ERROR,
						lex_pos, {SYM_W{1'b0}}});
				lex_state = start_state;
				lex_pos   = '0;
				lex_empty = 1'b1;
				lex_error = 1'b0;
			end
			default: begin
				if (!lex_error) begin
					arc = arc_tbl[lex_state][it.symbol];
					if (arc[STATE_W]) begin
						token_q.push_back({ST_EXTEND, lex_pos, it.symbol});
						take_arc(arc);
					end else begin
						st = ST_ERROR;
						// token ends: retry the byte from the start state
						if (accept_tbl[lex_state] && !lex_empty) begin
							lex_state = start_state;
							lex_empty = 1'b1;
							arc = arc_tbl[lex_state][it.symbol];
							if (arc[STATE_W])
								st = ST_BOUNDARY;
						end
						token_q.push_back({st, lex_pos, it.symbol});
						if (st == ST_BOUNDARY)
							take_arc(arc);
						else
							lex_error = 1'b1;
					end
				end
			end
		endcase
	endfunction

	function automatic void queue_item(mode_t m, logic [STATE_W-1:0] s, logic [SYM_W-1:0] sym,
			logic [STATE_W-1:0] nx, logic acc);
		pending_items.push_back({m, s, sym, nx, acc});
		items_queued++;
	endfunction

	// Scan byte with random don't-care fields
	function automatic void queue_byte(logic [SYM_W-1:0] sym);
		queue_item(MODE_SCAN, 6'($urandom_range(0, 63)), sym, 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)));
	endfunction

	function automatic void queue_end();
		queue_item(MODE_END, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
			6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic wait_drained();
		while (items_taken != items_queued || token_q.size() != 0)
			@(posedge clk);
	endtask

	// Write the start state once the scanner is idle
	task automatic set_start_state(logic [STATE_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		start_state  = v;
	endtask

	// Driver: present pending items, predict on acceptance
	always @(posedge clk) begin : drive
		bit show;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_token_result(in_item);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				show = 1'b0;
				if (in_pause > 0) begin
					in_pause--;
				end else if (pending_items.size() != 0) begin
					in_pause = next_pause(in_calm);
					if (in_pause == 0) begin
						in_item <= pending_items.pop_front();
						show = 1'b1;
					end else begin
						in_pause--;
					end
				end
				in_valid <= show;
			end
		end
	end

	// Monitor: check each token result against the oldest prediction
	always @(posedge clk) begin : watch
		token_result_t exp;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					note_failure($sformatf("unexpected result status=%0d pos=%0d byte=%02h",
						status, position, byte_out));
				end else begin
					exp = token_q.pop_front();
					if (status !== exp.status || position !== exp.pos || byte_out !== exp.echo)
						note_failure($sformatf(
							"mismatch: exp status=%0d pos=%0d byte=%02h, got %0d %0d %02h",
							exp.status, exp.pos, exp.echo, status, position, byte_out));
				end
			end
			if (out_pause > 0) begin
				out_pause--;
				out_ready <= 1'b0;
			end else begin
				out_pause = next_pause(out_calm);
				out_ready <= (out_pause == 0);
				if (out_pause != 0)
					out_pause--;
			end
		end
	end

	initial begin
		int                 n_st;
		int                 n_sym;
		int                 n_str;
		int                 len;
		int                 phase_no;
		logic [STATE_W-1:0] v;
		logic [STATE_W-1:0] states [6];
		logic [SYM_W-1:0]   alpha [6];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_start_state(6'd0);

		// Directed: errors, empty input, empty accepting lexeme, boundaries
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_end();
		queue_end();
		queue_item(MODE_FLAG, 6'd0, 8'hFF, 6'd63, 1'b1);
		queue_end();
		queue_byte(8'h11);
		queue_end();
		queue_item(MODE_LOAD, 6'd0, 8'h00, 6'd63, 1'b0);
		queue_item(MODE_LOAD, 6'd63, 8'hFF, 6'd63, 1'b1);
		queue_item(MODE_FLAG, 6'd63, 8'h00, 6'd0, 1'b1);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'h80);
		queue_end();
		queue_item(MODE_LOAD, 6'd0, 8'h7F, 6'd1, 1'b0);
		queue_byte(8'h7F);
		queue_end();
		queue_item(MODE_LOAD, 6'd63, 8'h55, 6'd0, 1'b0);
		queue_byte(8'h00);
		queue_byte(8'h55);
		queue_end();
		queue_item(MODE_FLAG, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_end();

		// Random phases: small DFA, then strings mostly over its alphabet
		phase_no = 0;
		while (items_queued < 1350) begin
			if (phase_no < 3 || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: v = 6'd0;
					1: v = 6'd63;
					default: v = 6'($urandom_range(0, 63));
				endcase
				if (phase_no == 0)
					v = 6'd63;
				set_start_state(v);
			end
			n_st = $urandom_range(2, 6);
			states[0] = start_state;
			for (int i = 1; i < n_st; i++)
				states[i] = 6'($urandom_range(0, 63));
			n_sym = $urandom_range(2, 6);
			for (int i = 0; i < n_sym; i++)
				alpha[i] = 8'($urandom_range(0, 255));
			for (int i = 0; i < n_st; i++)
				for (int j = 0; j < n_sym; j++)
					if ($urandom_range(0, 2) != 0)
						queue_item(MODE_LOAD, states[i], alpha[j],
							states[$urandom_range(0, n_st - 1)], 1'($urandom_range(0, 1)));
			for (int i = 0; i < n_st; i++)
				queue_item(MODE_FLAG, states[i], 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			n_str = $urandom_range(2, 6);
			for (int k = 0; k < n_str; k++) begin
				len = $urandom_range(0, 12);
				for (int b = 0; b < len; b++) begin
					// occasional noise item of any kind
					if ($urandom_range(0, 15) == 0)
						queue_item(mode_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
							8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
							1'($urandom_range(0, 1)));
					if ($urandom_range(0, 7) != 0)
						queue_byte(alpha[$urandom_range(0, n_sym - 1)]);
					else
						queue_byte(8'($urandom_range(0, 255)));
				end
				// sometimes leave the last string open across a start state change
				if (k != n_str - 1 || $urandom_range(0, 5) != 0)
					queue_end();
			end
			phase_no++;
		end

		// Tail without stalls: one long lexeme, items back to back
		wait_drained();
		quiet_tail = 1'b1;
		queue_item(MODE_LOAD, start_state, 8'hA5, start_state, 1'b0);
		queue_item(MODE_FLAG, start_state, 8'h00, 6'd0, 1'b1);
		queue_end();
		for (int i = 0; i < 60; i++)
			queue_byte(8'hA5);
		queue_end();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hang guard
	initial begin
		#6000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
src/dmm_pkg.sv
src/dfa_maximal_munch_scanner.sv
src/dmm_checker.sv
dv/testbench.sv
